>>> sv/atipd_pkg.sv
`default_nettype none

package atipd_pkg;

    // Default width of the length accumulator and the payload byte counter
    localparam int unsigned LEN_WIDTH_DEF = 16;

    // Longest literal pattern, in characters
    localparam int unsigned MAX_PAT = 6;

    typedef logic [2:0] prog_t;
    typedef logic [MAX_PAT-1:0][7:0] pat_t;

    // Entry 0 holds the first character of the pattern
    localparam pat_t IPD_PAT    = {8'h00, 8'h2C, 8'h44, 8'h50, 8'h49, 8'h2B}; // "+IPD,"
    localparam pat_t UNLINK_PAT = {8'h6B, 8'h6E, 8'h69, 8'h6C, 8'h6E, 8'h55}; // "Unlink"
    localparam prog_t IPD_LEN    = 3'd5;
    localparam prog_t UNLINK_LEN = 3'd6;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Event codes
    localparam logic [2:0] EV_CONSUMED  = 3'd0;
    localparam logic [2:0] EV_PAYLOAD   = 3'd1;
    localparam logic [2:0] EV_CLOSED    = 3'd2;
    localparam logic [2:0] EV_MALFORMED = 3'd3;
    localparam logic [2:0] EV_HEADER    = 3'd4;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  data_byte;
        logic [15:0] payload_length;
        logic        last_payload;
    } result_t;

endpackage

`default_nettype wire

>>> sv/at_modem_ipd_deframer.sv
// An accepted byte waits in the input stage; its result is registered in the
// result stage. Throughput: one byte per cycle while m_ready keeps up; each
// byte gives exactly one result. The figure is set by the per-byte state
// update, combinational in atipd_core. Reset: aresetn, synchronous, active low,
// clears both stages and returns the parser to hunting, matchers and counters at zero.
`default_nettype none

module at_modem_ipd_deframer #(
    parameter int unsigned LEN_WIDTH = atipd_pkg::LEN_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // received byte stream
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    // parser events
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_kind,
    output logic [7:0]       m_data_byte,
    output logic [15:0]      m_payload_length,
    output logic             m_last_payload
);

    // Input stage: holds one accepted byte.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // Result stage.
    logic               out_valid_reg, out_valid_next;
    atipd_pkg::result_t result_reg;
    atipd_pkg::result_t result_next;

    // Parser state, updated when a byte moves from input to result stage.
    atipd_pkg::phase_t    phase_reg, phase_next;
    atipd_pkg::prog_t     ipd_prog_reg, ipd_prog_next;
    atipd_pkg::prog_t     unl_prog_reg, unl_prog_next;
    logic [LEN_WIDTH-1:0] accum_reg, accum_next;
    logic [LEN_WIDTH-1:0] left_reg, left_next;

    logic out_free;   // result stage can take a new result this cycle
    logic step;       // the byte in the input stage is processed this cycle
    logic s_xfer;

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    // input stage frees up in the same cycle its byte moves on
    assign s_ready  = !in_valid_reg || out_free;
    assign s_xfer   = s_valid && s_ready;

    atipd_core #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_core (
        .rx_byte       (in_byte_reg),
        .phase         (phase_reg),
        .ipd_prog      (ipd_prog_reg),
        .unl_prog      (unl_prog_reg),
        .accum         (accum_reg),
        .left          (left_reg),
        .phase_next    (phase_next),
        .ipd_prog_next (ipd_prog_next),
        .unl_prog_next (unl_prog_next),
        .accum_next    (accum_next),
        .left_next     (left_next),
        .result        (result_next)
    );

    always_comb begin
        in_valid_next = s_xfer ? 1'b1 : (step ? 1'b0 : in_valid_reg);
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= atipd_pkg::PH_HUNT;
            ipd_prog_reg  <= '0;
            unl_prog_reg  <= '0;
            accum_reg     <= '0;
            left_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step) begin
                phase_reg    <= phase_next;
                ipd_prog_reg <= ipd_prog_next;
                unl_prog_reg <= unl_prog_next;
                accum_reg    <= accum_next;
                left_reg     <= left_next;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_rx_byte;
        end
        if (step) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_event_kind     = result_reg.event_kind;
    assign m_data_byte      = result_reg.data_byte;
    assign m_payload_length = result_reg.payload_length;
    assign m_last_payload   = result_reg.last_payload;

endmodule

`default_nettype wire

>>> sv/atipd_match.sv
`default_nettype none

// One literal matcher step, naive restart: on a mismatch retry the byte
// once against the first character.
module atipd_match (
    input  wire logic [7:0]      rx_byte,
    input  wire atipd_pkg::prog_t prog,
    input  wire atipd_pkg::pat_t  pat,
    input  wire atipd_pkg::prog_t pat_len,
    output atipd_pkg::prog_t      prog_next,
    output logic                  done
);

    atipd_pkg::prog_t p;

    always_comb begin
        p = (prog >= pat_len) ? '0 : prog;
        if (rx_byte == pat[p]) begin
            prog_next = p + 3'd1;
        end else if (p != '0) begin
            prog_next = (rx_byte == pat[0]) ? 3'd1 : 3'd0;
        end else begin
            prog_next = p;
        end
        done = (prog_next == pat_len);
    end

endmodule

`default_nettype wire

>>> sv/atipd_core.sv
`default_nettype none

// Per-byte next state and result.
module atipd_core #(
    parameter int unsigned LEN_WIDTH = atipd_pkg::LEN_WIDTH_DEF
) (
    input  wire logic [7:0]           rx_byte,
    input  wire atipd_pkg::phase_t    phase,
    input  wire atipd_pkg::prog_t     ipd_prog,
    input  wire atipd_pkg::prog_t     unl_prog,
    input  wire logic [LEN_WIDTH-1:0] accum,
    input  wire logic [LEN_WIDTH-1:0] left,
    output atipd_pkg::phase_t         phase_next,
    output atipd_pkg::prog_t          ipd_prog_next,
    output atipd_pkg::prog_t          unl_prog_next,
    output logic [LEN_WIDTH-1:0]      accum_next,
    output logic [LEN_WIDTH-1:0]      left_next,
    output atipd_pkg::result_t        result
);

    atipd_pkg::prog_t ipd_step;
    atipd_pkg::prog_t unl_step;
    logic             ipd_done;
    logic             unl_done;
    logic             is_digit;
    logic [LEN_WIDTH+3:0]  acc_ext;
    logic [LEN_WIDTH+3:0]  mul10;
    logic [LEN_WIDTH+15:0] plen_ext;
    logic [LEN_WIDTH-1:0]  left_dec;

    atipd_match u_ipd (
        .rx_byte   (rx_byte),
        .prog      (ipd_prog),
        .pat       (atipd_pkg::IPD_PAT),
        .pat_len   (atipd_pkg::IPD_LEN),
        .prog_next (ipd_step),
        .done      (ipd_done)
    );

    atipd_match u_unl (
        .rx_byte   (rx_byte),
        .prog      (unl_prog),
        .pat       (atipd_pkg::UNLINK_PAT),
        .pat_len   (atipd_pkg::UNLINK_LEN),
        .prog_next (unl_step),
        .done      (unl_done)
    );

    assign is_digit = (rx_byte >= atipd_pkg::CH_ZERO) && (rx_byte <= atipd_pkg::CH_NINE);
    assign acc_ext  = {4'b0000, accum};
    // accum * 10 + digit, never overflows LEN_WIDTH + 4 bits
    assign mul10    = (acc_ext << 3) + (acc_ext << 1)
                    + (LEN_WIDTH+4)'(rx_byte - atipd_pkg::CH_ZERO);
    assign plen_ext = {16'h0000, accum};
    assign left_dec = (left != '0) ? left - 1'b1 : left;

    always_comb begin
        phase_next    = phase;
        ipd_prog_next = ipd_prog;
        unl_prog_next = unl_prog;
        accum_next    = accum;
        left_next     = left;
        result        = '0;
        result.event_kind = atipd_pkg::EV_CONSUMED;

        case (phase)
            atipd_pkg::PH_HEADER: begin
                if (rx_byte == atipd_pkg::CH_COLON) begin
                    // zero length keeps collecting digits
                    if (accum != '0) begin
                        left_next                = accum;
                        result.payload_length    = plen_ext[15:0];
                        result.event_kind        = atipd_pkg::EV_HEADER;
                        phase_next               = atipd_pkg::PH_PAYLOAD;
                    end
                end else if (!is_digit) begin
                    result.event_kind = atipd_pkg::EV_MALFORMED;
                    phase_next        = atipd_pkg::PH_HUNT;
                    ipd_prog_next     = '0;
                    unl_prog_next     = '0;
                end else if (|mul10[LEN_WIDTH+3:LEN_WIDTH]) begin
                    accum_next = '1;
                end else begin
                    accum_next = mul10[LEN_WIDTH-1:0];
                end
            end
            atipd_pkg::PH_PAYLOAD: begin
                result.event_kind = atipd_pkg::EV_PAYLOAD;
                result.data_byte  = rx_byte;
                left_next         = left_dec;
                if (left_dec == '0) begin
                    result.last_payload = 1'b1;
                    phase_next          = atipd_pkg::PH_HUNT;
                    ipd_prog_next       = '0;
                    unl_prog_next       = '0;
                end
            end
            default: begin
                // hunting; unused phase codes land here too
                phase_next = atipd_pkg::PH_HUNT;
                if (ipd_done) begin
                    ipd_prog_next = '0;
                    unl_prog_next = '0;
                    accum_next    = '0;
                    left_next     = '0;
                    phase_next    = atipd_pkg::PH_HEADER;
                end else if (unl_done) begin
                    ipd_prog_next     = '0;
                    unl_prog_next     = '0;
                    result.event_kind = atipd_pkg::EV_CLOSED;
                end else begin
                    ipd_prog_next = ipd_step;
                    unl_prog_next = unl_step;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/atipd_chk.sv
`default_nettype none

module atipd_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [7:0]  s_rx_byte,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_event_kind,
    input wire logic [7:0]  m_data_byte,
    input wire logic [15:0] m_payload_length,
    input wire logic        m_last_payload
);

    // waiting byte holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_rx_byte))
        else $error("input byte changed while waiting");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind)
            && $stable(m_data_byte) && $stable(m_payload_length)
            && $stable(m_last_payload))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_kind <= atipd_pkg::EV_HEADER)
        else $error("bad event code");

    a_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != atipd_pkg::EV_PAYLOAD
            |-> m_data_byte == 8'h00 && !m_last_payload)
        else $error("data or last mark outside payload event");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != atipd_pkg::EV_HEADER |-> m_payload_length == 16'h0000)
        else $error("length outside header event");

endmodule

bind at_modem_ipd_deframer atipd_chk u_atipd_chk (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_rx_byte        (s_rx_byte),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_event_kind     (m_event_kind),
    .m_data_byte      (m_data_byte),
    .m_payload_length (m_payload_length),
    .m_last_payload   (m_last_payload)
);

`default_nettype wire

>>> verif/testbench.sv
module testbench;

    // Ceiling of the header length accumulator; a longer length saturates here
    localparam logic [31:0] LEN_CEIL = (32'd1 << atipd_pkg::LEN_WIDTH_DEF) - 1;

    // Hard stop on a hung run. Most of a correct run goes to the phases with
    // heavy idling or stalling.
    localparam int CYCLE_LIMIT = 200000;

    // Random part: byte transfers in each idling phase
    localparam int BYTES_PER_PHASE = 260;

    // ------------------------------------------------------------------
    // Event tracker: mirrors the deframer state, predicts one event per
    // accepted byte, and checks events in arrival order.
    // ------------------------------------------------------------------
    class deframe_tracker;
        atipd_pkg::phase_t                   phase;
        atipd_pkg::prog_t                    ipd_prog;
        atipd_pkg::prog_t                    unlink_prog;
        logic [atipd_pkg::LEN_WIDTH_DEF-1:0] len_accum;
        logic [atipd_pkg::LEN_WIDTH_DEF-1:0] bytes_left;
        atipd_pkg::result_t                  pending_events[$];
        int                                  mismatches;

        function new();
            phase       = atipd_pkg::PH_HUNT;
            ipd_prog    = '0;
            unlink_prog = '0;
            len_accum   = '0;
            bytes_left  = '0;
            mismatches  = 0;
        endfunction

        // One step of a literal matcher; a miss restarts and retries the
        // same byte against the first pattern character
        function atipd_pkg::prog_t advance(atipd_pkg::prog_t p, atipd_pkg::pat_t pat,
                                           atipd_pkg::prog_t plen, logic [7:0] c);
            atipd_pkg::prog_t q;
            q = (p >= plen) ? '0 : p;
            if (c == pat[q]) begin
                q = q + 1'b1;
            end else if (q != 0) begin
                q = (c == pat[0]) ? atipd_pkg::prog_t'(1) : atipd_pkg::prog_t'(0);
            end
            return q;
        endfunction

        function atipd_pkg::result_t predict_event(logic [7:0] c);
            atipd_pkg::result_t ev;
            logic [31:0]        grown;
            ev = '0;
            ev.event_kind = atipd_pkg::EV_CONSUMED;
            case (phase)
                atipd_pkg::PH_HEADER: begin
                    if (c == atipd_pkg::CH_COLON) begin
                        // zero length: stay in the header, keep accumulating
                        if (len_accum != 0) begin
                            bytes_left        = len_accum;
                            ev.payload_length = 16'(len_accum);
                            ev.event_kind     = atipd_pkg::EV_HEADER;
                            phase             = atipd_pkg::PH_PAYLOAD;
                        end
                    end else if (c < atipd_pkg::CH_ZERO || c > atipd_pkg::CH_NINE) begin
                        ev.event_kind = atipd_pkg::EV_MALFORMED;
                        phase         = atipd_pkg::PH_HUNT;
                        ipd_prog      = '0;
                        unlink_prog   = '0;
                    end else begin
                        grown = 32'(len_accum) * 10 + 32'(c - atipd_pkg::CH_ZERO);
                        len_accum = (grown > LEN_CEIL)
                                  ? LEN_CEIL[atipd_pkg::LEN_WIDTH_DEF-1:0]
                                  : grown[atipd_pkg::LEN_WIDTH_DEF-1:0];
                    end
                end
                atipd_pkg::PH_PAYLOAD: begin
                    ev.event_kind = atipd_pkg::EV_PAYLOAD;
                    ev.data_byte  = c;
                    if (bytes_left != 0) begin
                        bytes_left = bytes_left - 1'b1;
                    end
                    if (bytes_left == 0) begin
                        ev.last_payload = 1'b1;
                        phase           = atipd_pkg::PH_HUNT;
                        ipd_prog        = '0;
                        unlink_prog     = '0;
                    end
                end
                default: begin
                    // "+IPD," has priority; on its completion the unlink
                    // matcher never sees the byte
                    phase    = atipd_pkg::PH_HUNT;
                    ipd_prog = advance(ipd_prog, atipd_pkg::IPD_PAT, atipd_pkg::IPD_LEN, c);
                    if (ipd_prog == atipd_pkg::IPD_LEN) begin
                        ipd_prog    = '0;
                        unlink_prog = '0;
                        len_accum   = '0;
                        bytes_left  = '0;
                        phase       = atipd_pkg::PH_HEADER;
                    end else begin
                        unlink_prog = advance(unlink_prog, atipd_pkg::UNLINK_PAT,
                                              atipd_pkg::UNLINK_LEN, c);
                        if (unlink_prog == atipd_pkg::UNLINK_LEN) begin
                            ipd_prog      = '0;
                            unlink_prog   = '0;
                            ev.event_kind = atipd_pkg::EV_CLOSED;
                        end
                    end
                end
            endcase
            return ev;
        endfunction

        function void note_byte(logic [7:0] c);
            pending_events.push_back(predict_event(c));
        endfunction

        function void check_event(atipd_pkg::result_t got);
            atipd_pkg::result_t want;
            if (pending_events.size() == 0) begin
                $display("%0t: event with none pending, got kind %0d data %0h len %0d last %0b",
                         $time, got.event_kind, got.data_byte, got.payload_length,
                         got.last_payload);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            if (got.event_kind !== want.event_kind) begin
                $display("%0t: event_kind mismatch, expected %0d, got %0d",
                         $time, want.event_kind, got.event_kind);
                mismatches++;
            end
            if (got.data_byte !== want.data_byte) begin
                $display("%0t: data_byte mismatch, expected %0h, got %0h",
                         $time, want.data_byte, got.data_byte);
                mismatches++;
            end
            if (got.payload_length !== want.payload_length) begin
                $display("%0t: payload_length mismatch, expected %0d, got %0d",
                         $time, want.payload_length, got.payload_length);
                mismatches++;
            end
            if (got.last_payload !== want.last_payload) begin
                $display("%0t: last_payload mismatch, expected %0b, got %0b",
                         $time, want.last_payload, got.last_payload);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block signals. All inputs start at known values.
    // ------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [2:0]  m_event_kind;
    logic [7:0]  m_data_byte;
    logic [15:0] m_payload_length;
    logic        m_last_payload;

    int send_idle_pct = 0;   // chance, in percent, of a gap before a byte
    int stall_pct     = 0;   // chance, in percent, of m_ready low in a cycle
    int sent_count    = 0;
    int cycle_count   = 0;

    deframe_tracker tracker;

    initial begin
        forever #6 aclk = ~aclk;
    end

    at_modem_ipd_deframer u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_data_byte      (m_data_byte),
        .m_payload_length (m_payload_length),
        .m_last_payload   (m_last_payload)
    );

    // ------------------------------------------------------------------
    // Event side: check each transfer on the m_ channel, then pick the
    // next cycle's ready. Values read here are the pre-edge ones.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_event({m_event_kind, m_data_byte, m_payload_length,
                                 m_last_payload});
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------

    // Offer one byte, with random gaps ahead of it, and hold it until the
    // transfer happens. The tracker learns of the byte at that edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_byte(b);
        sent_count++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // Half the time a character that matters to the parser, else any byte
    function automatic logic [7:0] pick_char();
        string cs = "+IPD,Unlink:0123456789";
        if ($urandom_range(1)) begin
            return 8'($urandom_range(255));
        end
        return cs[$urandom_range(cs.len() - 1)];
    endfunction

    // Any byte that ends a header as malformed
    function automatic logic [7:0] pick_non_digit();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while ((b >= atipd_pkg::CH_ZERO && b <= atipd_pkg::CH_NINE)
                   || b == atipd_pkg::CH_COLON);
        return b;
    endfunction

    // One random sequence: mostly complete frames with random payload,
    // plus link-closed lines, bad headers, broken patterns and noise
    task automatic random_sequence();
        int    roll;
        int    len;
        int    cut;
        string hdr;
        string pat;
        roll = $urandom_range(99);
        if (roll < 60) begin
            hdr = "+IPD,";
            if ($urandom_range(99) < 10) hdr = {hdr, ":"};   // zero length at ':'
            if ($urandom_range(99) < 15) hdr = {hdr, "0"};   // leading zero
            len = ($urandom_range(99) < 10) ? $urandom_range(1, 300) : $urandom_range(1, 12);
            hdr = {hdr, $sformatf("%0d", len), ":"};
            send_str(hdr);
            repeat (len) send_byte(pick_char());
        end else if (roll < 70) begin
            send_str("Unlink");
        end else if (roll < 78) begin
            hdr = "+IPD,";
            if ($urandom_range(1)) hdr = {hdr, $sformatf("%0d", $urandom_range(0, 999))};
            send_str(hdr);
            send_byte(pick_non_digit());
        end else if (roll < 88) begin
            // pattern cut short by a random byte
            pat = $urandom_range(1) ? "+IPD," : "Unlink";
            cut = $urandom_range(1, pat.len() - 1);
            send_str(pat.substr(0, cut - 1));
            send_byte(pick_char());
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(pick_char());
        end
    endtask

    task automatic random_phase(input int idle, input int stall);
        int goal;
        send_idle_pct = idle;
        stall_pct     = stall;
        goal          = sent_count + BYTES_PER_PHASE;
        while (sent_count < goal) random_sequence();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        tracker = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, no idling on either side
        send_byte(8'h00);                      // extreme bytes while hunting
        send_byte(8'hFF);
        send_str("+IPD,3:");                   // frame with extreme payload bytes
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(atipd_pkg::CH_COLON);        // ':' inside payload is data
        send_str("Unlink");                    // link closed
        send_str("+IPD,:0:2:ab");              // zero length at ':' stays in header
        send_str("+IPD,4x");                   // non-digit header byte
        send_str("+IPD,/");                    // just below '0'
        send_str("+IPD,;");                    // just above '9' and ':'
        send_str("Unlin+IPD,Zk");              // "+IPD," completes first, clears unlink
        send_str("++IPD,1:Q");                 // restart retries the same byte
        send_str("UUnlink");
        send_str("+IPD,6:Unlink");             // patterns inside payload pass through

        // Random part across the idling phases
        random_phase(0, 0);
        random_phase(84, 0);
        random_phase(0, 84);
        random_phase(18, 18);

        // Saturated length last: the header event shows the ceiling, and the
        // run ends partway into its payload
        send_str("+IPD,70000:");
        repeat (4) send_byte(8'($urandom_range(255)));

        s_valid <= 1'b0;
        while (tracker.pending_events.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);   // room for a stray extra event

        if (tracker.mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
